// File: hdl/nrhs_pkg.sv
package nrhs_pkg;

  localparam int POSITIONS_DEF  = 1024;
  localparam int COUNT_BITS_DEF = 16;
  localparam int POS_W          = 10;
  localparam int SUM_W          = 48;

  localparam logic KIND_ADD   = 1'b0;
  localparam logic KIND_SERVE = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [POS_W-1:0] position;
  } in_word_t;

  typedef struct packed {
    logic             served;
    logic [POS_W-1:0] served_position;
    logic [POS_W-1:0] moved_distance;
    logic [SUM_W-1:0] total_distance;
    logic             heading_left;
  } out_word_t;

endpackage

// File: hdl/nearest_request_head_scheduler.sv
// Channel | Handshake       | Payload                 | Direction
// in      | in_valid/ready  | nrhs_pkg::in_word_t     | into block
// out     | out_valid/ready | nrhs_pkg::out_word_t    | out of block
//
// One word is taken at a time; in_ready stays low until the result has left.
// An add that fills an empty slot first rebuilds that slot's leaf-to-root
// summary path before its word returns. A serve with a move scans the tree for
// each side level by level, then takes one request and rebuilds the path if
// that slot empties. After reset a clearing pass walks the memories first.
// The result sits in an output register; a stalled out channel holds it.
module nearest_request_head_scheduler #(
  parameter int POSITIONS  = nrhs_pkg::POSITIONS_DEF,
  parameter int COUNT_BITS = nrhs_pkg::COUNT_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  nrhs_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output nrhs_pkg::out_word_t out_data
);

  localparam int LEVELS = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;
  localparam int LEAVES = 1 << LEVELS;
  localparam int IW     = LEVELS + 1;          // tree node index width
  localparam int QW     = IW + 1;              // query bound width, reaches 2*LEAVES
  localparam int PW     = nrhs_pkg::POS_W;
  localparam int SW     = nrhs_pkg::SUM_W;
  localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};
  localparam logic [SW-1:0] SMAX = {SW{1'b1}};

  typedef struct packed {
    logic              valid;
    logic [LEVELS-1:0] lo;
    logic [LEVELS-1:0] hi;
  } node_t;

  localparam logic [4:0] S_CLR  = 5'd0,  S_IDLE = 5'd1,  S_CRD  = 5'd2,
                         S_CCHK = 5'd3,  S_UPA  = 5'd4,  S_UPB  = 5'd5,
                         S_UPC  = 5'd6,  S_UPW  = 5'd7,  S_QRD  = 5'd8,
                         S_QCHK = 5'd9,  S_DEC  = 5'd10, S_OUT  = 5'd11;

  logic [4:0] state;

  // memories
  logic [COUNT_BITS-1:0] cmem [LEAVES];
  node_t                 tmem [2*LEAVES];
  logic [COUNT_BITS-1:0] crd;
  node_t                 trd;
  logic                  cwe, twe;
  logic [LEVELS-1:0]     caddr;
  logic [COUNT_BITS-1:0] cwd;
  logic [IW-1:0]         taddr;
  node_t                 twd;

  always_ff @(posedge clk) begin
    if (cwe) cmem[caddr] <= cwd;
    crd <= cmem[caddr];
  end
  always_ff @(posedge clk) begin
    if (twe) tmem[taddr] <= twd;
    trd <= tmem[taddr];
  end

  // working registers
  logic [IW-1:0]         clr_cnt;
  logic                  is_serve;
  logic [LEVELS-1:0]     slot;       // slot being counted or updated
  logic                  slot_ok;
  logic [COUNT_BITS-1:0] cnt;
  logic                  occ_new;
  logic [IW-1:0]         node;       // current tree node
  node_t                 acc;        // merged child during update
  logic                  side_right; // query side
  logic [QW-1:0]         ql, qr;     // query bounds, half open
  logic                  qphase;     // 0 left bound read, 1 right
  node_t                 lres, rres;
  logic [LEVELS-1:0]     head;
  logic                  tleft;
  logic [SW-1:0]         dsum;
  logic                  served;
  logic [PW-1:0]         moved;
  logic                  do_upd;

  function automatic node_t merge(node_t a, node_t b);
    node_t m;
    if (!a.valid) return b;
    if (!b.valid) return a;
    m.valid = 1'b1;
    m.lo = (a.lo < b.lo) ? a.lo : b.lo;
    m.hi = (a.hi > b.hi) ? a.hi : b.hi;
    return m;
  endfunction

  // distances
  logic [LEVELS-1:0] dl, dr;
  logic              go_left;
  assign dl = head - lres.hi;
  assign dr = rres.lo - head;
  always_comb begin
    if (!rres.valid)      go_left = 1'b1;
    else if (!lres.valid) go_left = 1'b0;
    else if (dl < dr)     go_left = 1'b1;
    else if (dr < dl)     go_left = 1'b0;
    else                  go_left = tleft;
  end

  // memory port steering
  always_comb begin
    cwe = 1'b0; twe = 1'b0;
    caddr = slot; cwd = cnt;
    taddr = node; twd = acc;
    unique case (state)
      S_CLR: begin
        cwe = 1'b1; twe = 1'b1;
        caddr = clr_cnt[LEVELS-1:0];
        cwd = '0;
        taddr = clr_cnt;
        twd = '0;
      end
      S_CCHK: begin
        caddr = slot;
        cwd = cnt;
        cwe = 1'b1;
      end
      S_UPA: begin
        taddr = node;
        twd = acc;
        twe = 1'b1;
      end
      S_UPB: taddr = node ^ IW'(1);
      S_QRD: taddr = qphase ? IW'(qr - QW'(1)) : IW'(ql);
      default: ;
    endcase
  end

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      clr_cnt <= '0;
      out_valid <= 1'b0;
      head <= '0;
      tleft <= 1'b0;
      dsum <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + IW'(1);
          if (clr_cnt == IW'(2*LEAVES-1)) state <= S_IDLE;
        end
        S_IDLE: if (in_valid && in_ready) begin
          is_serve <= (in_data.kind == nrhs_pkg::KIND_SERVE);
          served <= 1'b0;
          moved <= '0;
          do_upd <= 1'b0;
          if (in_data.kind == nrhs_pkg::KIND_SERVE) begin
            slot <= head;
            slot_ok <= 1'b1;
          end else begin
            slot <= in_data.position[LEVELS-1:0];
            slot_ok <= (int'(in_data.position) < POSITIONS);
          end
          state <= S_CRD;
        end
        S_CRD: state <= S_CCHK;  // count read in flight
        S_CCHK: begin
          // crd is the count at slot; the count write goes out this cycle
          if (!is_serve) begin
            state <= S_OUT;
            if (slot_ok && crd != CMAX) begin
              do_upd <= (crd == '0);
              occ_new <= 1'b1;
            end else do_upd <= 1'b0;
          end else if (crd != '0 || do_upd) begin
            // head slot or chosen slot: take one
            state <= S_OUT;
            served <= 1'b1;
            occ_new <= 1'b0;
            do_upd <= (crd == COUNT_BITS'(1));
          end else begin
            // query left then right
            do_upd <= 1'b0;
            side_right <= 1'b0;
            ql <= QW'(LEAVES);
            qr <= QW'(LEAVES) + QW'(head);
            qphase <= 1'b0;
            lres <= '0;
            rres <= '0;
            state <= S_QRD;
          end
        end
        S_QRD: begin
          // decide whether this bound reads a node
          if (ql >= qr) begin
            if (!side_right) begin
              side_right <= 1'b1;
              ql <= QW'(LEAVES) + QW'(head) + QW'(1);
              qr <= QW'(LEAVES) + QW'(POSITIONS);
              qphase <= 1'b0;
              if (32'(head) + 1 >= POSITIONS) state <= S_DEC;
            end else state <= S_DEC;
          end else if (!qphase) begin
            if (ql[0]) state <= S_QCHK; else qphase <= 1'b1;
          end else begin
            if (qr[0]) state <= S_QCHK;
            else begin
              ql <= ql >> 1; qr <= qr >> 1; qphase <= 1'b0;
            end
          end
        end
        S_QCHK: begin
          if (!side_right) lres <= merge(lres, trd);
          else rres <= merge(rres, trd);
          if (!qphase) begin
            ql <= ql + QW'(1);
            qphase <= 1'b1;
          end else begin
            ql <= ql >> 1;
            qr <= (qr - QW'(1)) >> 1;
            qphase <= 1'b0;
          end
          state <= S_QRD;
        end
        S_DEC: begin
          if (lres.valid || rres.valid) begin
            served <= 1'b1;
            if (go_left) begin
              moved <= PW'(dl); head <= lres.hi; slot <= lres.hi; tleft <= 1'b1;
              dsum <= (SMAX - dsum < SW'(dl)) ? SMAX : dsum + SW'(dl);
            end else begin
              moved <= PW'(dr); head <= rres.lo; slot <= rres.lo; tleft <= 1'b0;
              dsum <= (SMAX - dsum < SW'(dr)) ? SMAX : dsum + SW'(dr);
            end
            do_upd <= 1'b1;   // marks a forced take in S_CCHK
            state <= S_CRD;
          end else state <= S_OUT;
        end
        S_OUT: begin
          if (do_upd) begin
            // rebuild leaf path
            node <= IW'(LEAVES) + IW'(slot);
            acc.valid <= occ_new;
            acc.lo <= slot;
            acc.hi <= slot;
            do_upd <= 1'b0;
            state <= S_UPA;
          end else begin
            out_valid <= 1'b1;
            out_data.served <= served;
            out_data.served_position <= PW'(head);
            out_data.moved_distance <= moved;
            out_data.total_distance <= dsum;
            out_data.heading_left <= tleft;
            state <= S_IDLE;
          end
        end
        S_UPA: begin
          if (node == IW'(1)) state <= S_OUT;
          else state <= S_UPB;
        end
        S_UPB: state <= S_UPC;
        S_UPC: begin
          acc <= merge(acc, trd);
          node <= node >> 1;
          state <= S_UPA;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // count write value follows the decision made from crd
  always_comb begin
    cnt = crd;
    if (!is_serve) begin
      if (slot_ok && crd != CMAX) cnt = crd + COUNT_BITS'(1);
    end else if (crd != '0) cnt = crd - COUNT_BITS'(1);
  end

endmodule
